>>> rtl/grr_pkg.sv
package grr_pkg;

	localparam int unsigned DataW = 32;
	localparam int unsigned CfgW  = 5;
	localparam int unsigned ApbW  = 32;
	localparam int unsigned AddrW = 3;

	localparam logic [CfgW-1:0] GroupSizeReset = CfgW'(2);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RD   = 3'b010,
		S_OUT  = 3'b100
	} state_t;

endpackage

>>> rtl/group_reverse_reorder_unit.sv
// Sequence: an item that completes a group, or ends the list, moves the unit to S_RD, where the
// first result is read from the buffer, and then to S_OUT, where it is offered; each further result
// of the run passes through S_RD and S_OUT again. Throughput: one item per cycle while a group fills;
// a run holds the input off until its last result is taken, set by the single read port of the buffer.
// Reset: fill count clears, group_size returns to 2, buffer contents stay undefined.
module group_reverse_reorder_unit #(
	parameter int unsigned GROUP_MAX = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [grr_pkg::DataW-1:0]     s_axis_tdata,   // value[31:0]
	input  logic                          s_axis_tlast,   // end_of_list
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [grr_pkg::DataW-1:0]     m_axis_tdata,   // out_value[31:0]
	output logic                          m_axis_tlast,   // last_of_run
	output logic                          m_axis_tuser,   // list_done
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [grr_pkg::AddrW-1:0]     paddr,
	input  logic [grr_pkg::ApbW-1:0]      pwdata,
	output logic [grr_pkg::ApbW-1:0]      prdata,
	output logic                          pready
);

	localparam int unsigned AW = (GROUP_MAX > 1) ? $clog2(GROUP_MAX) : 1;
	localparam int unsigned CW = $clog2(GROUP_MAX + 1);
	localparam int unsigned EW = (CW > grr_pkg::CfgW) ? CW : grr_pkg::CfgW;

	logic [grr_pkg::DataW-1:0] mem [GROUP_MAX];
	logic [grr_pkg::DataW-1:0] rdata_q;

	grr_pkg::state_t           state_q;
	logic [grr_pkg::CfgW-1:0]  group_size_q;
	logic [CW-1:0]             fill_q;
	logic [CW-1:0]             rem_q;
	logic [AW-1:0]             addr_q;
	logic                      rev_q;
	logic                      end_q;

	logic                      in_xfer;
	logic                      out_xfer;
	logic                      cfg_wr;
	logic                      has_room;
	logic [EW-1:0]             cfg_ext;
	logic [EW-1:0]             g_eff;
	logic [EW-1:0]             n;
	logic                      emit_rev;

	assign pready        = 1'b1;
	assign cfg_wr        = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
	assign prdata        = (paddr[2] == 1'b0) ? grr_pkg::ApbW'(group_size_q) : '0;

	assign s_axis_tready = (state_q == grr_pkg::S_IDLE);
	assign m_axis_tvalid = (state_q == grr_pkg::S_OUT);
	assign m_axis_tdata  = rdata_q;
	assign m_axis_tlast  = (rem_q == CW'(1));
	assign m_axis_tuser  = m_axis_tlast && end_q;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_xfer = m_axis_tvalid && m_axis_tready;
	assign has_room = (fill_q < CW'(GROUP_MAX));

	always_comb begin
		cfg_ext = EW'(group_size_q);
		priority if (cfg_ext == '0) begin
			g_eff = EW'(1);
		end else if (cfg_ext > EW'(GROUP_MAX)) begin
			g_eff = EW'(GROUP_MAX);
		end else begin
			g_eff = cfg_ext;
		end
		n        = EW'(fill_q) + (has_room ? EW'(1) : EW'(0));
		emit_rev = (n >= g_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= grr_pkg::GroupSizeReset;
		end else if (cfg_wr) begin
			group_size_q <= pwdata[grr_pkg::CfgW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= grr_pkg::S_IDLE;
			fill_q  <= '0;
			rem_q   <= '0;
			addr_q  <= '0;
			rev_q   <= 1'b0;
			end_q   <= 1'b0;
		end else begin
			unique case (state_q)
				grr_pkg::S_IDLE: begin
					if (in_xfer) begin
						priority if (emit_rev) begin
							rem_q   <= CW'(n);
							addr_q  <= AW'(n - EW'(1));
							rev_q   <= 1'b1;
							end_q   <= s_axis_tlast;
							fill_q  <= '0;
							state_q <= grr_pkg::S_RD;
						end else if (s_axis_tlast) begin
							rem_q   <= CW'(n);
							addr_q  <= '0;
							rev_q   <= 1'b0;
							end_q   <= 1'b1;
							fill_q  <= '0;
							state_q <= grr_pkg::S_RD;
						end else begin
							fill_q  <= CW'(n);
						end
					end
				end
				grr_pkg::S_RD: begin
					state_q <= grr_pkg::S_OUT;
				end
				grr_pkg::S_OUT: begin
					if (out_xfer) begin
						rem_q  <= rem_q - CW'(1);
						addr_q <= rev_q ? (addr_q - AW'(1)) : (addr_q + AW'(1));
						if (rem_q == CW'(1)) begin
							state_q <= grr_pkg::S_IDLE;
						end else begin
							state_q <= grr_pkg::S_RD;
						end
					end
				end
				default: begin
					state_q <= grr_pkg::S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && has_room) begin
			mem[AW'(fill_q)] <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == grr_pkg::S_RD) begin
			rdata_q <= mem[addr_q];
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid)
		else $error("input ready while a result is shown");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("list_done without last_of_run");

	a_run_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && m_axis_tlast |=> s_axis_tready)
		else $error("input not reopened after end of run");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < CW'(GROUP_MAX))
		else $error("fill count reached buffer depth");

	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != grr_pkg::S_IDLE) |-> (rem_q != '0))
		else $error("drain with no results left");

endmodule
